// ===== src/tsb_pkg.sv =====
// Shared types and codes of the timer slot bank.
package tsb_pkg;

  // Item modes
  localparam logic [1:0] ModeArmOneShot  = 2'd0;
  localparam logic [1:0] ModeArmPeriodic = 2'd1;
  localparam logic [1:0] ModeCancel      = 2'd2;
  localparam logic [1:0] ModeDispatch    = 2'd3;

  // Result kinds
  localparam logic [2:0] KindArmed     = 3'd0;
  localparam logic [2:0] KindFull      = 3'd1;
  localparam logic [2:0] KindCancelled = 3'd2;
  localparam logic [2:0] KindFired     = 3'd3;
  localparam logic [2:0] KindNoneDue   = 3'd4;

  // At most this many fired results per dispatch item
  localparam logic [2:0] FireMax = 3'd4;

  localparam int unsigned TickW = 32;
  localparam int unsigned TagW  = 16;

  // Sign bit of (now - due): clear means the slot is due
  localparam int unsigned DueSignBit = TickW - 1;

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StArm    = 5'b00010,
    StCancel = 5'b00100,
    StScan   = 5'b01000,
    StFire   = 5'b10000
  } state_e;

  typedef struct packed {
    logic [TickW-1:0] a;
    logic [TickW-1:0] b;
    logic             sub;
  } alu_req_t;

endpackage

// ===== src/tsb_alu.sv =====
// Shared 32-bit add/subtract unit of the timer slot bank.
module tsb_alu
  import tsb_pkg::*;
(
  input  alu_req_t         req_i,
  output logic [TickW-1:0] sum_o
);

  logic [TickW-1:0] b_eff;

  assign b_eff = req_i.b ^ {TickW{req_i.sub}};
  assign sum_o = req_i.a + b_eff + {{(TickW-1){1'b0}}, req_i.sub};

endmodule

// ===== src/timer_slot_bank_top.sv =====
// Top level of the timer slot bank: slot table, sequencer and output register.
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+-------------------------------------------
//  in      | in  | in_valid_i / in_ready_o   | mode_i, now_i, delay_or_period_i,
//          |     |                           | slot_id_i, tag_i
//  out     | out | out_valid_o / out_ready_i | kind_o, slot_o, fired_tag_o, last_o
//
// Arm and cancel: the item is accepted, then the result is loaded into the output register.
// Dispatch: the item is accepted, then each slot is scanned in turn through the shared adder
// (now - due), then one result is loaded per fired slot (or one none-due result), while the same adder
// re-arms a periodic slot (due + period). in_ready_o is high only while the sequencer idles.
// Reset clears the active bits, the sequencer and the output valid; slot contents are left.
// A stalled output holds the sequencer in its result-loading state; nothing is dropped.
module timer_slot_bank_top
  import tsb_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           mode_i,
  input  logic [TickW-1:0]     now_i,
  input  logic [TickW-1:0]     delay_or_period_i,
  input  logic [7:0]           slot_id_i,
  input  logic [TagW-1:0]      tag_i,

  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           kind_o,
  output logic [1:0]           slot_o,
  output logic [TagW-1:0]      fired_tag_o,
  output logic                 last_o
);

  localparam int unsigned IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOT_COUNT - 1);

  // Control state
  state_e                  state_q, state_d;
  logic [SLOT_COUNT-1:0]   active_q, active_d;
  logic [SLOT_COUNT-1:0]   due_vec_q, due_vec_d;   // slots found due by the scan
  logic [IdxW-1:0]         idx_q, idx_d;           // scan position
  logic [2:0]              cnt_q, cnt_d;           // due slots collected so far
  logic                    out_valid_q, out_valid_d;

  // Captured item
  logic [1:0]              mode_q;
  logic [TickW-1:0]        now_q;
  logic [TickW-1:0]        dp_q;
  logic [7:0]              id_q;
  logic [TagW-1:0]         tag_q;

  // Slot table (contents undefined until armed)
  logic                    periodic_q [SLOT_COUNT];
  logic [TickW-1:0]        due_q      [SLOT_COUNT];
  logic [TickW-1:0]        period_q   [SLOT_COUNT];
  logic [TagW-1:0]         slot_tag_q [SLOT_COUNT];

  // Output register payload
  logic [2:0]              kind_q;
  logic [IdxW-1:0]         slot_idx_q;
  logic [TagW-1:0]         fired_tag_q;
  logic                    last_q;

  // Sequencer outputs
  logic                    in_take;
  logic                    out_free;
  logic                    out_load;
  logic [2:0]              res_kind;
  logic [IdxW-1:0]         res_idx;
  logic [TagW-1:0]         res_tag;
  logic                    res_last;
  logic                    slot_we;
  logic                    due_we;

  // Priority encoders
  logic [IdxW-1:0]         free_idx;
  logic                    free_any;
  logic [IdxW-1:0]         fire_idx;
  logic [SLOT_COUNT-1:0]   fire_rest;

  // Shared adder
  alu_req_t                alu_req;
  logic [TickW-1:0]        alu_sum;

  logic [IdxW+1:0]         slot_ext;

  assign in_ready_o = (state_q == StIdle);
  assign out_free   = !out_valid_q || out_ready_i;

  // Lowest free slot for arm; lowest due slot for firing.
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    fire_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_idx = IdxW'(i);
        free_any = 1'b1;
      end
      if (due_vec_q[i]) begin
        fire_idx = IdxW'(i);
      end
    end
  end

  always_comb begin
    fire_rest = due_vec_q;
    fire_rest[fire_idx] = 1'b0;
  end

  // Pick adder operands by sequencer step.
  always_comb begin
    alu_req = '0;
    case (state_q)
      StScan: begin
        alu_req.a   = now_q;
        alu_req.b   = due_q[idx_q];
        alu_req.sub = 1'b1;
      end
      StArm: begin
        alu_req.a   = now_q;
        alu_req.b   = dp_q;
        alu_req.sub = 1'b0;
      end
      default: begin
        alu_req.a   = due_q[fire_idx];
        alu_req.b   = period_q[fire_idx];
        alu_req.sub = 1'b0;
      end
    endcase
  end

  tsb_alu u_alu (
    .req_i (alu_req),
    .sum_o (alu_sum)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    due_vec_d   = due_vec_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_take     = 1'b0;
    out_load    = 1'b0;
    res_kind    = KindNoneDue;
    res_idx     = '0;
    res_tag     = '0;
    res_last    = 1'b1;
    slot_we     = 1'b0;
    due_we      = 1'b0;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          in_take = 1'b1;
          case (mode_i)
            ModeArmOneShot, ModeArmPeriodic: state_d = StArm;
            ModeCancel:                      state_d = StCancel;
            default: begin
              idx_d     = '0;
              due_vec_d = '0;
              cnt_d     = '0;
              state_d   = StScan;
            end
          endcase
        end
      end

      StArm: begin
        if (out_free) begin
          out_load = 1'b1;
          if (free_any) begin
            active_d[free_idx] = 1'b1;
            slot_we  = 1'b1;
            res_kind = KindArmed;
            res_idx  = free_idx;
          end else begin
            res_kind = KindFull;
          end
          state_d = StIdle;
        end
      end

      StCancel: begin
        if (out_free) begin
          out_load = 1'b1;
          res_kind = KindCancelled;
          // ignore ids past the table
          if (id_q < 8'(SLOT_COUNT)) begin
            active_d[id_q[IdxW-1:0]] = 1'b0;
          end
          state_d = StIdle;
        end
      end

      StScan: begin
        if (active_q[idx_q] && !alu_sum[DueSignBit] && (cnt_q != FireMax)) begin
          due_vec_d[idx_q] = 1'b1;
          cnt_d = cnt_q + 3'd1;
        end
        if (idx_q == LastIdx) begin
          state_d = StFire;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end

      StFire: begin
        if (out_free) begin
          out_load = 1'b1;
          if (due_vec_q == '0) begin
            res_kind = KindNoneDue;
            state_d  = StIdle;
          end else begin
            res_kind  = KindFired;
            res_idx   = fire_idx;
            res_tag   = slot_tag_q[fire_idx];
            res_last  = (fire_rest == '0);
            due_vec_d = fire_rest;
            // re-arm periodic slots, free one-shot slots
            if (periodic_q[fire_idx]) begin
              due_we = 1'b1;
            end else begin
              active_d[fire_idx] = 1'b0;
            end
            if (fire_rest == '0) begin
              state_d = StIdle;
            end
          end
        end
      end

      default: state_d = StIdle;
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      active_q    <= '0;
      due_vec_q   <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      due_vec_q   <= due_vec_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Item capture, slot table and result payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      mode_q <= mode_i;
      now_q  <= now_i;
      dp_q   <= delay_or_period_i;
      id_q   <= slot_id_i;
      tag_q  <= tag_i;
    end
    if (slot_we) begin
      periodic_q[free_idx] <= (mode_q == ModeArmPeriodic);
      due_q[free_idx]      <= alu_sum;
      period_q[free_idx]   <= (mode_q == ModeArmPeriodic) ? dp_q : '0;
      slot_tag_q[free_idx] <= tag_q;
    end
    if (due_we) begin
      due_q[fire_idx] <= alu_sum;
    end
    if (out_load) begin
      kind_q      <= res_kind;
      slot_idx_q  <= res_idx;
      fired_tag_q <= res_tag;
      last_q      <= res_last;
    end
  end

  // Slot field carries the low two bits of the index.
  assign slot_ext = {2'b00, slot_idx_q};

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign slot_o      = slot_ext[1:0];
  assign fired_tag_o = fired_tag_q;
  assign last_o      = last_q;

endmodule
